FILE: design/kfc_pkg.sv
// Package for the keypad calculator: payload structs, key decode, command
// and operator codes, and back-end state type. No dependencies.
`default_nettype none

package kfc_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int SHOWN_WIDTH       = 32;
    localparam int QUEUE_DEPTH       = 2;

    // Input beat: one keypad event
    typedef struct packed {
        logic [3:0] key;
        logic       released;
    } t_in_item;

    // Output beat: one display update
    typedef struct packed {
        logic                           show_valid;
        logic signed [SHOWN_WIDTH-1:0]  shown_value;
        logic                           done_res;
    } t_out_item;

    typedef enum logic [2:0] {
        OPER_NONE = 3'd0,
        OPER_ADD  = 3'd1,
        OPER_SUB  = 3'd2,
        OPER_MUL  = 3'd3,
        OPER_DIV  = 3'd4
    } t_oper;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_DIGIT,
        CMD_OPER,
        CMD_EQUALS,
        CMD_EXIT
    } t_cmd_kind;

    // Classified key event handed from front to back
    typedef struct packed {
        t_cmd_kind  kind;
        logic [3:0] digit;
        t_oper      oper;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_WRITE
    } t_back_state;

    // Fixed 4x4 key map, row-major:
    //   1 2 3 +  /  4 5 6 -  /  7 8 9 *  /  exit 0 = /
    function automatic t_cmd decode_key(input logic [3:0] key, input logic released);
        t_cmd c;
        c.kind  = CMD_DIGIT;
        c.digit = 4'd0;
        c.oper  = OPER_NONE;
        unique case (key)
            4'd0:  c.digit = 4'd1;
            4'd1:  c.digit = 4'd2;
            4'd2:  c.digit = 4'd3;
            4'd3:  begin c.kind = CMD_OPER; c.oper = OPER_ADD; end
            4'd4:  c.digit = 4'd4;
            4'd5:  c.digit = 4'd5;
            4'd6:  c.digit = 4'd6;
            4'd7:  begin c.kind = CMD_OPER; c.oper = OPER_SUB; end
            4'd8:  c.digit = 4'd7;
            4'd9:  c.digit = 4'd8;
            4'd10: c.digit = 4'd9;
            4'd11: begin c.kind = CMD_OPER; c.oper = OPER_MUL; end
            4'd12: c.kind = CMD_EXIT;
            4'd13: c.digit = 4'd0;
            4'd14: c.kind = CMD_EQUALS;
            4'd15: begin c.kind = CMD_OPER; c.oper = OPER_DIV; end
            default: c.kind = CMD_NOP;
        endcase
        // Releases still produce a beat, but change nothing
        if (released) begin
            c.kind = CMD_NOP;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: design/kfc_front.sv
// Front end: accepts keypad event beats, decodes them into commands and
// holds one command for the queue. Depends on kfc_pkg.
`default_nettype none

module kfc_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire kfc_pkg::t_in_item i_in_item,
    output logic                   o_cmd_valid,
    input  wire logic              i_cmd_ready,
    output kfc_pkg::t_cmd          o_cmd
);
    import kfc_pkg::*;

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;

    // Take a new beat whenever the holding register is empty or draining
    assign o_in_ready = !r_valid || i_cmd_ready;

    always_comb begin
        n_valid = r_valid;
        if (o_in_ready) begin
            n_valid = i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Decode on accept
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd <= decode_key(i_in_item.key, i_in_item.released);
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

`default_nettype wire

FILE: design/kfc_queue.sv
// Short command queue between the decoding front end and the execution
// back end. Depends on kfc_pkg.
`default_nettype none

module kfc_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  wire kfc_pkg::t_cmd i_push_cmd,
    output logic               o_pop_valid,
    input  wire logic          i_pop_ready,
    output kfc_pkg::t_cmd      o_pop_cmd
);
    import kfc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with pointers apart");
`endif

endmodule

`default_nettype wire

FILE: design/kfc_back.sv
// Back end: calculator state, shared iterative multiply/divide unit and the
// output register. Depends on kfc_pkg.
`default_nettype none

module kfc_back #(
    parameter int OPERAND_WIDTH = kfc_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_ready,
    input  wire kfc_pkg::t_cmd i_cmd,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output kfc_pkg::t_out_item o_out_item
);
    import kfc_pkg::*;

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(W + 1);

    t_back_state r_state,    n_state;
    logic [W-1:0] r_first,   n_first;
    logic [W-1:0] r_second,  n_second;
    logic         r_entering, n_entering;
    t_oper        r_oper,    n_oper;
    logic         r_exit,    n_exit;
    t_cmd         r_cmd,     n_cmd;
    logic [W-1:0] r_a,       n_a;
    logic [W-1:0] r_b,       n_b;
    logic [W-1:0] r_acc,     n_acc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic         r_neg,     n_neg;
    logic         r_out_valid, n_out_valid;
    t_out_item    r_out,     n_out;

    logic         out_free;
    logic         need_apply;
    logic [W-1:0] mag_first;
    logic [W-1:0] mag_second;
    logic [W-1:0] imm_val;
    logic [W-1:0] unit_val;
    logic [W:0]   div_trial;
    logic [W-1:0] cur_operand;
    logic [W-1:0] digit_val;
    logic         do_commit;
    t_cmd         sel_cmd;
    logic [W-1:0] sel_val;
    logic signed [W-1:0] s_show_val;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Operand magnitudes for signed division
    assign mag_first  = r_first[W-1]  ? (~r_first + 1'b1)  : r_first;
    assign mag_second = r_second[W-1] ? (~r_second + 1'b1) : r_second;

    assign need_apply = (i_cmd.kind == CMD_EQUALS)
                     || ((i_cmd.kind == CMD_OPER) && r_entering);

    // Combinational results; multiply never lands here, division only by zero
    always_comb begin
        unique case (r_oper)
            OPER_ADD: imm_val = r_first + r_second;
            OPER_SUB: imm_val = r_first - r_second;
            default:  imm_val = '0;
        endcase
    end

    assign unit_val  = (r_oper == OPER_DIV) ? (r_neg ? (~r_b + 1'b1) : r_b) : r_acc;
    assign div_trial = {r_acc, r_b[W-1]} - {1'b0, r_a};

    // Digit entry: operand * 10 + digit, wrapping at W bits
    assign cur_operand = r_entering ? r_second : r_first;
    assign digit_val   = (cur_operand << 3) + (cur_operand << 1) + W'(i_cmd.digit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_first     <= '0;
            r_second    <= '0;
            r_entering  <= 1'b0;
            r_oper      <= OPER_NONE;
            r_exit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_first     <= n_first;
            r_second    <= n_second;
            r_entering  <= n_entering;
            r_oper      <= n_oper;
            r_exit      <= n_exit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        r_out <= n_out;
    end

    // Sequencer, iterative unit and state update
    always_comb begin
        n_state     = r_state;
        n_first     = r_first;
        n_second    = r_second;
        n_entering  = r_entering;
        n_oper      = r_oper;
        n_exit      = r_exit;
        n_cmd       = r_cmd;
        n_a         = r_a;
        n_b         = r_b;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_cmd_ready = 1'b0;
        do_commit   = 1'b0;
        sel_cmd     = i_cmd;
        sel_val     = imm_val;
        s_show_val  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (need_apply && (r_oper == OPER_MUL)) begin
                        o_cmd_ready = 1'b1;
                        n_cmd   = i_cmd;
                        n_a     = r_first;
                        n_b     = r_second;
                        n_acc   = '0;
                        n_cnt   = CNT_W'(W);
                        n_state = ST_MUL;
                    end else if (need_apply && (r_oper == OPER_DIV) && (r_second != '0)) begin
                        o_cmd_ready = 1'b1;
                        n_cmd   = i_cmd;
                        n_a     = mag_second;
                        n_b     = mag_first;
                        n_acc   = '0;
                        n_neg   = r_first[W-1] ^ r_second[W-1];
                        n_cnt   = CNT_W'(W);
                        n_state = ST_DIV;
                    end else if (out_free) begin
                        o_cmd_ready = 1'b1;
                        do_commit   = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                // One multiplier bit per cycle, low half only
                n_acc = r_acc + (r_b[0] ? r_a : '0);
                n_a   = r_a << 1;
                n_b   = r_b >> 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_WRITE;
                end
            end
            ST_DIV: begin
                // Restoring division, one quotient bit per cycle
                if (!div_trial[W]) begin
                    n_acc = div_trial[W-1:0];
                    n_b   = {r_b[W-2:0], 1'b1};
                end else begin
                    n_acc = {r_acc[W-2:0], r_b[W-1]};
                    n_b   = {r_b[W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                sel_cmd = r_cmd;
                sel_val = unit_val;
                if (out_free) begin
                    do_commit = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // Commit one command: update calculator state and load the output
        if (do_commit) begin
            n_out_valid      = 1'b1;
            n_out.show_valid = 1'b0;
            unique case (sel_cmd.kind)
                CMD_DIGIT: begin
                    if (r_entering) begin
                        n_second = digit_val;
                    end else begin
                        n_first = digit_val;
                    end
                    n_out.show_valid = 1'b1;
                    s_show_val       = digit_val;
                end
                CMD_EXIT: begin
                    n_exit = 1'b1;
                end
                CMD_EQUALS: begin
                    n_out.show_valid = 1'b1;
                    s_show_val       = sel_val;
                    n_first          = '0;
                    n_second         = '0;
                    n_entering       = 1'b0;
                    n_oper           = OPER_NONE;
                end
                CMD_OPER: begin
                    n_oper = sel_cmd.oper;
                    if (!r_entering) begin
                        n_entering = 1'b1;
                    end else begin
                        n_first          = sel_val;
                        n_second         = '0;
                        n_out.show_valid = 1'b1;
                        s_show_val       = sel_val;
                    end
                end
                default: ;
            endcase
            n_out.shown_value = SHOWN_WIDTH'(s_show_val);
            n_out.done_res    = n_exit;
        end
    end

`ifndef NO_ASSERTIONS
    a_unit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_MUL) || (r_state == ST_DIV)) |-> (r_cnt != '0))
        else $error("iterative unit running with zero count");

    a_exit_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exit |=> r_exit)
        else $error("exit flag cleared");

    a_done_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> r_exit)
        else $error("done reported without exit");

    a_blank_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.show_valid) |-> (r_out.shown_value == '0))
        else $error("nonzero value without display update");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_cmd_ready)
        else $error("command taken while unit busy");
`endif

endmodule

`default_nettype wire

FILE: design/keypad_four_function_calculator_unit.sv
// Top level of the keypad calculator: front decoder, command queue and
// execution back end. Depends on kfc_pkg, kfc_front, kfc_queue, kfc_back.
`default_nettype none

// Every keypad event beat yields exactly one output beat. A beat passes through
// the front decode register, then waits in a two-entry queue for the back
// end. Digits, exit, releases, add, subtract and any operation with no
// operator or a zero divisor are committed straight from the idle state.
// Multiply and divide run on one shared shift-and-add / restoring-divide unit
// that handles one bit per cycle, in the ST_MUL or ST_DIV state and then
// ST_WRITE, before the result reaches the output register. The output
// register holds a result while the consumer stalls; the back end keeps a
// multiply or divide running meanwhile but commits nothing until that result
// is taken.
module keypad_four_function_calculator_unit #(
    parameter int OPERAND_WIDTH = kfc_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire kfc_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output kfc_pkg::t_out_item      o_out_item
);
    import kfc_pkg::*;

    logic fr_valid;
    logic fr_ready;
    t_cmd fr_cmd;
    logic q_valid;
    logic q_ready;
    t_cmd q_cmd;

    kfc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_cmd_valid (fr_valid),
        .i_cmd_ready (fr_ready),
        .o_cmd       (fr_cmd)
    );

    kfc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fr_valid),
        .o_push_ready (fr_ready),
        .i_push_cmd   (fr_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_cmd    (q_cmd)
    );

    kfc_back #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
